>>> design/bpa_pkg.sv
// Shared constants, types and state codes of the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

   localparam int ORDER_LIMIT   = 11;
   localparam int PAGE_CAPACITY = 4096;

   localparam int FRAME_W = 12;
   localparam int ORD_W   = 4;
   localparam int CNT_W   = 13;
   localparam int REC_W   = $clog2(PAGE_CAPACITY);
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 1;
   // split halves of a misplaced block can run past the last frame
   localparam int REC_FRAME_W = FRAME_W + 1;

   localparam logic [STAT_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BAD_ORD = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_PAGES = 1'd1;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_REBUILD_INIT,
      ST_CARVE,
      ST_IDLE,
      ST_ALLOC_POP,
      ST_SPLIT,
      ST_PUSH_RD,
      ST_PUSH_WR,
      ST_WALK_START,
      ST_WALK_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [REC_FRAME_W-1:0] frame;
      logic [REC_W-1:0]       link;
      logic                   link_ok;
   } rec_type;

   typedef struct packed {
      logic             clear;
      logic             pop;
      logic             release_en;
      logic [REC_W-1:0] release_rec;
   } spare_ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [REC_W-1:0] top_rec;
   } spare_stat_type;

endpackage

>>> design/bpa_spare_stack.sv
// Stack of unused record indices, held in a memory with a low-water mark.
`timescale 1ns / 1ps
module bpa_spare_stack (
   input  logic                     clock,
   input  logic                     reset,
   input  bpa_pkg::spare_ctl_type   ctl,
   output bpa_pkg::spare_stat_type  stat
);

   localparam logic [bpa_pkg::CNT_W-1:0] CAP = bpa_pkg::CNT_W'(bpa_pkg::PAGE_CAPACITY);
   localparam logic [bpa_pkg::REC_W-1:0] REC_MAX =
      bpa_pkg::REC_W'(bpa_pkg::PAGE_CAPACITY - 1);

   logic [bpa_pkg::REC_W-1:0] mem [bpa_pkg::PAGE_CAPACITY];

   logic [bpa_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [bpa_pkg::CNT_W-1:0] lw_ff, lw_in;
   logic [bpa_pkg::REC_W-1:0] q_ff;
   logic [bpa_pkg::REC_W-1:0] pos_ff;
   logic                      hit_ff;
   logic [bpa_pkg::CNT_W-1:0] below;
   logic                      can_pop;
   logic                      can_push;

   assign below    = cnt_ff - 1'b1;
   assign can_pop  = ctl.pop && (cnt_ff != '0);
   assign can_push = ctl.release_en && (cnt_ff < CAP);

   // entries at or above the low-water mark have been written since the rebuild
   always_ff @(posedge clock) begin
      if (can_push) begin
         mem[cnt_ff[bpa_pkg::REC_W-1:0]] <= ctl.release_rec;
      end
      if (can_pop) begin
         q_ff   <= mem[below[bpa_pkg::REC_W-1:0]];
         pos_ff <= below[bpa_pkg::REC_W-1:0];
         hit_ff <= (below >= lw_ff);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      lw_in  = lw_ff;
      if (ctl.clear) begin
         cnt_in = CAP;
         lw_in  = CAP;
      end else if (can_pop) begin
         cnt_in = below;
         if (below < lw_ff) begin
            lw_in = below;
         end
      end else if (can_push) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CAP;
         lw_ff  <= CAP;
      end else begin
         cnt_ff <= cnt_in;
         lw_ff  <= lw_in;
      end
   end

   assign stat.count   = cnt_ff;
   assign stat.top_rec = hit_ff ? q_ff : (REC_MAX - pos_ff);

endmodule

>>> design/buddy_page_allocator_top.sv
// Buddy page allocator: free lists in a record memory, sequenced read-modify-write.
// Allocate: pop the smallest fitting block, push one half per split level, then post.
// Free: walk each order's list for the buddy, merge, then push the final block and post.
// One request at a time; the record memory's read and write ports set the pace.
// Reset and every register write rebuild the lists by carving the range into blocks
// (at most 13), during which no request is taken.
`timescale 1ns / 1ps
module buddy_page_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [3:0]                    req_block_order,
   input  logic [11:0]                   req_frame_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [11:0]                   rsp_granted_frame,
   output logic [1:0]                    rsp_status,
   output logic [3:0]                    rsp_merged_order,
   output logic [12:0]                   rsp_free_page_total,
   input  logic                          csr_write_enable,
   input  logic [bpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [12:0]                   csr_write_data
);

   localparam int L = bpa_pkg::ORDER_LIMIT;
   localparam logic [bpa_pkg::CNT_W-1:0] CAP = bpa_pkg::CNT_W'(bpa_pkg::PAGE_CAPACITY);

   bpa_pkg::state_type state_ff, state_in;

   logic [bpa_pkg::FRAME_W-1:0] base_cfg_ff;
   logic [bpa_pkg::CNT_W-1:0]   pages_cfg_ff;

   logic [bpa_pkg::REC_W-1:0] head_ff [L];
   logic [bpa_pkg::REC_W-1:0] head_in [L];
   logic [L-1:0]              head_ok_ff, head_ok_in;

   logic [bpa_pkg::CNT_W-1:0]       sum_ff, sum_in;
   logic [bpa_pkg::CNT_W-1:0]       carve_frame_ff, carve_frame_in;
   logic [bpa_pkg::CNT_W-1:0]       left_ff, left_in;
   logic                            carving_ff, carving_in;
   logic                            act_ff, act_in;
   logic [bpa_pkg::ORD_W-1:0]       want_ord_ff, want_ord_in;
   logic [bpa_pkg::ORD_W-1:0]       cur_ord_ff, cur_ord_in;
   logic [bpa_pkg::FRAME_W-1:0]     frame_ff, frame_in;
   logic [bpa_pkg::FRAME_W-1:0]     mate_ff, mate_in;
   logic [bpa_pkg::REC_FRAME_W-1:0] base_ff, base_in;
   logic [bpa_pkg::REC_W-1:0]       cur_rec_ff, cur_rec_in;
   logic [bpa_pkg::REC_W-1:0]       prev_rec_ff, prev_rec_in;
   logic [bpa_pkg::REC_FRAME_W-1:0] prev_frame_ff, prev_frame_in;
   logic                            have_prev_ff, have_prev_in;
   logic [bpa_pkg::ORD_W-1:0]       push_ord_ff, push_ord_in;
   logic [bpa_pkg::REC_FRAME_W-1:0] push_frame_ff, push_frame_in;
   logic [bpa_pkg::STAT_W-1:0]      status_ff, status_in;
   logic [bpa_pkg::FRAME_W-1:0]     granted_ff, granted_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::FRAME_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic [bpa_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [bpa_pkg::ORD_W-1:0]   rsp_merged_ff, rsp_merged_in;
   logic [bpa_pkg::CNT_W-1:0]   rsp_total_ff, rsp_total_in;

   bpa_pkg::rec_type          rec_mem [bpa_pkg::PAGE_CAPACITY];
   bpa_pkg::rec_type          rec_q_ff;
   bpa_pkg::rec_type          rec_wr_data;
   logic                      rec_wr_en;
   logic [bpa_pkg::REC_W-1:0] rec_wr_addr;
   logic [bpa_pkg::REC_W-1:0] rec_rd_addr;

   bpa_pkg::spare_ctl_type  spare_ctl;
   bpa_pkg::spare_stat_type spare_stat;

   logic [bpa_pkg::ORD_W-1:0] find_ord;
   logic                      find_ok;
   logic [bpa_pkg::ORD_W-1:0] carve_ord;
   logic [bpa_pkg::CNT_W-1:0] carve_pg;
   logic [bpa_pkg::CNT_W-1:0] cur_pg;
   logic [bpa_pkg::CNT_W-1:0] push_pg;
   logic [bpa_pkg::CNT_W-1:0] avail;
   logic [bpa_pkg::ORD_W-1:0] split_ord;
   bpa_pkg::state_type        after_push;

   bpa_spare_stack u_spare (
      .clock (clock),
      .reset (reset),
      .ctl   (spare_ctl),
      .stat  (spare_stat)
   );

   always_ff @(posedge clock) begin
      if (rec_wr_en) begin
         rec_mem[rec_wr_addr] <= rec_wr_data;
      end
      rec_q_ff <= rec_mem[rec_rd_addr];
   end

   always_comb begin
      find_ok  = 1'b0;
      find_ord = '0;
      for (int o = L - 1; o >= 0; o--) begin
         if (o >= int'(req_block_order) && head_ok_ff[o]) begin
            find_ok  = 1'b1;
            find_ord = bpa_pkg::ORD_W'(o);
         end
      end
      carve_ord = '0;
      for (int o = 0; o < L; o++) begin
         if ((bpa_pkg::CNT_W'(1) << o) <= left_ff) begin
            carve_ord = bpa_pkg::ORD_W'(o);
         end
      end
   end

   assign carve_pg  = bpa_pkg::CNT_W'(1) << carve_ord;
   assign cur_pg    = bpa_pkg::CNT_W'(1) << cur_ord_ff;
   assign push_pg   = bpa_pkg::CNT_W'(1) << push_ord_ff;
   assign avail     = CAP - {1'b0, base_cfg_ff};
   assign split_ord = cur_ord_ff - 1'b1;

   always_comb begin
      if (carving_ff) begin
         after_push = bpa_pkg::ST_CARVE;
      end else if (act_ff == bpa_pkg::ACT_FREE) begin
         after_push = bpa_pkg::ST_DONE;
      end else begin
         after_push = bpa_pkg::ST_SPLIT;
      end
   end

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      head_ok_in     = head_ok_ff;
      sum_in         = sum_ff;
      carve_frame_in = carve_frame_ff;
      left_in        = left_ff;
      carving_in     = carving_ff;
      act_in         = act_ff;
      want_ord_in    = want_ord_ff;
      cur_ord_in     = cur_ord_ff;
      frame_in       = frame_ff;
      mate_in        = mate_ff;
      base_in        = base_ff;
      cur_rec_in     = cur_rec_ff;
      prev_rec_in    = prev_rec_ff;
      prev_frame_in  = prev_frame_ff;
      have_prev_in   = have_prev_ff;
      push_ord_in    = push_ord_ff;
      push_frame_in  = push_frame_ff;
      status_in      = status_ff;
      granted_in     = granted_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_merged_in  = rsp_merged_ff;
      rsp_total_in   = rsp_total_ff;
      rec_wr_en      = 1'b0;
      rec_wr_addr    = '0;
      rec_wr_data    = '0;
      rec_rd_addr    = '0;
      spare_ctl      = '0;

      unique case (state_ff)
         bpa_pkg::ST_REBUILD_INIT: begin
            head_ok_in      = '0;
            sum_in          = '0;
            spare_ctl.clear = 1'b1;
            carve_frame_in  = {1'b0, base_cfg_ff};
            left_in         = (pages_cfg_ff > avail) ? avail : pages_cfg_ff;
            carving_in      = 1'b1;
            state_in        = bpa_pkg::ST_CARVE;
         end
         bpa_pkg::ST_CARVE: begin
            if (left_ff == '0) begin
               carving_in = 1'b0;
               state_in   = bpa_pkg::ST_IDLE;
            end else begin
               push_ord_in    = carve_ord;
               push_frame_in  = carve_frame_ff;
               carve_frame_in = carve_frame_ff + carve_pg;
               left_in        = left_ff - carve_pg;
               state_in       = bpa_pkg::ST_PUSH_RD;
            end
         end
         bpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in      = req_action;
               want_ord_in = req_block_order;
               frame_in    = req_frame_number;
               granted_in  = '0;
               status_in   = bpa_pkg::STATUS_DONE;
               cur_ord_in  = req_block_order;
               if (int'(req_block_order) >= L) begin
                  status_in = bpa_pkg::STATUS_BAD_ORD;
                  state_in  = bpa_pkg::ST_DONE;
               end else if (req_action == bpa_pkg::ACT_ALLOC) begin
                  if (!find_ok) begin
                     status_in = bpa_pkg::STATUS_NO_FREE;
                     state_in  = bpa_pkg::ST_DONE;
                  end else begin
                     cur_ord_in  = find_ord;
                     rec_rd_addr = head_ff[find_ord];
                     state_in    = bpa_pkg::ST_ALLOC_POP;
                  end
               end else begin
                  state_in = bpa_pkg::ST_WALK_START;
               end
            end
         end
         bpa_pkg::ST_ALLOC_POP: begin
            base_in                 = rec_q_ff.frame;
            head_in[cur_ord_ff]     = rec_q_ff.link;
            head_ok_in[cur_ord_ff]  = rec_q_ff.link_ok;
            sum_in                  = sum_ff - cur_pg;
            spare_ctl.release_en    = 1'b1;
            spare_ctl.release_rec   = head_ff[cur_ord_ff];
            state_in                = bpa_pkg::ST_SPLIT;
         end
         bpa_pkg::ST_SPLIT: begin
            if (cur_ord_ff > want_ord_ff) begin
               cur_ord_in    = split_ord;
               push_ord_in   = split_ord;
               push_frame_in = base_ff + (bpa_pkg::REC_FRAME_W'(1) << split_ord);
               state_in      = bpa_pkg::ST_PUSH_RD;
            end else begin
               granted_in = base_ff[bpa_pkg::FRAME_W-1:0];
               state_in   = bpa_pkg::ST_DONE;
            end
         end
         bpa_pkg::ST_PUSH_RD: begin
            if (spare_stat.count == '0) begin
               state_in = after_push;
            end else begin
               spare_ctl.pop = 1'b1;
               state_in      = bpa_pkg::ST_PUSH_WR;
            end
         end
         bpa_pkg::ST_PUSH_WR: begin
            rec_wr_en               = 1'b1;
            rec_wr_addr             = spare_stat.top_rec;
            rec_wr_data.frame       = push_frame_ff;
            rec_wr_data.link        = head_ff[push_ord_ff];
            rec_wr_data.link_ok     = head_ok_ff[push_ord_ff];
            head_in[push_ord_ff]    = spare_stat.top_rec;
            head_ok_in[push_ord_ff] = 1'b1;
            sum_in                  = sum_ff + push_pg;
            state_in                = after_push;
         end
         bpa_pkg::ST_WALK_START: begin
            push_ord_in   = cur_ord_ff;
            push_frame_in = {1'b0, frame_ff};
            state_in      = bpa_pkg::ST_PUSH_RD;
            if (int'(cur_ord_ff) < L - 1) begin
               mate_in = frame_ff ^ (bpa_pkg::FRAME_W'(1) << cur_ord_ff);
               if (head_ok_ff[cur_ord_ff]) begin
                  rec_rd_addr  = head_ff[cur_ord_ff];
                  cur_rec_in   = head_ff[cur_ord_ff];
                  have_prev_in = 1'b0;
                  state_in     = bpa_pkg::ST_WALK_CHK;
               end
            end
         end
         bpa_pkg::ST_WALK_CHK: begin
            if (rec_q_ff.frame == {1'b0, mate_ff}) begin
               if (have_prev_ff) begin
                  rec_wr_en           = 1'b1;
                  rec_wr_addr         = prev_rec_ff;
                  rec_wr_data.frame   = prev_frame_ff;
                  rec_wr_data.link    = rec_q_ff.link;
                  rec_wr_data.link_ok = rec_q_ff.link_ok;
               end else begin
                  head_in[cur_ord_ff]    = rec_q_ff.link;
                  head_ok_in[cur_ord_ff] = rec_q_ff.link_ok;
               end
               sum_in                = sum_ff - cur_pg;
               spare_ctl.release_en  = 1'b1;
               spare_ctl.release_rec = cur_rec_ff;
               if (mate_ff < frame_ff) begin
                  frame_in = mate_ff;
               end
               cur_ord_in = cur_ord_ff + 1'b1;
               state_in   = bpa_pkg::ST_WALK_START;
            end else if (rec_q_ff.link_ok) begin
               prev_rec_in   = cur_rec_ff;
               prev_frame_in = rec_q_ff.frame;
               have_prev_in  = 1'b1;
               cur_rec_in    = rec_q_ff.link;
               rec_rd_addr   = rec_q_ff.link;
            end else begin
               push_ord_in   = cur_ord_ff;
               push_frame_in = {1'b0, frame_ff};
               state_in      = bpa_pkg::ST_PUSH_RD;
            end
         end
         bpa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = granted_ff;
               rsp_status_in  = status_ff;
               rsp_merged_in  = (act_ff == bpa_pkg::ACT_FREE &&
                                 status_ff == bpa_pkg::STATUS_DONE) ? cur_ord_ff : '0;
               rsp_total_in   = sum_ff;
               state_in       = bpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpa_pkg::ST_REBUILD_INIT;
         end
      endcase

      if (csr_write_enable) begin
         state_in = bpa_pkg::ST_REBUILD_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpa_pkg::ST_REBUILD_INIT;
         base_cfg_ff  <= '0;
         pages_cfg_ff <= CAP;
         head_ok_ff   <= '0;
         sum_ff       <= '0;
         carving_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ok_ff   <= head_ok_in;
         sum_ff       <= sum_in;
         carving_ff   <= carving_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               bpa_pkg::CSR_RANGE_BASE:
                  base_cfg_ff <= csr_write_data[bpa_pkg::FRAME_W-1:0];
               bpa_pkg::CSR_RANGE_PAGES:
                  pages_cfg_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff        <= head_in;
      carve_frame_ff <= carve_frame_in;
      left_ff        <= left_in;
      act_ff         <= act_in;
      want_ord_ff    <= want_ord_in;
      cur_ord_ff     <= cur_ord_in;
      frame_ff       <= frame_in;
      mate_ff        <= mate_in;
      base_ff        <= base_in;
      cur_rec_ff     <= cur_rec_in;
      prev_rec_ff    <= prev_rec_in;
      prev_frame_ff  <= prev_frame_in;
      have_prev_ff   <= have_prev_in;
      push_ord_ff    <= push_ord_in;
      push_frame_ff  <= push_frame_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_merged_ff  <= rsp_merged_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign req_stall           = (state_ff != bpa_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_frame   = rsp_granted_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_merged_order    = rsp_merged_ff;
   assign rsp_free_page_total = rsp_total_ff;

   a_beat_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == bpa_pkg::ST_DONE))
      else $error("result beat raised outside completion");

   a_csr_rebuilds: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> req_stall)
      else $error("request taken during rebuild");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == bpa_pkg::STATUS_DONE ||
                     rsp_status == bpa_pkg::STATUS_NO_FREE ||
                     rsp_status == bpa_pkg::STATUS_BAD_ORD))
      else $error("undefined status code");

   a_spare_bound: assert property (@(posedge clock) disable iff (reset)
      spare_stat.count <= CAP)
      else $error("spare record count beyond capacity");

endmodule

>>> bench/tb.sv
// Testbench for the buddy page allocator: random and directed requests against a predictor.
`timescale 1ns / 1ps
module tb;

   typedef struct {
      logic [11:0] granted;
      logic [1:0]  status;
      logic [3:0]  merged;
      logic [12:0] total;
   } outcome_type;

   class alloc_scoreboard;
      logic [12:0] free_list[bpa_pkg::ORDER_LIMIT][$];
      int          recs_used;
      logic [12:0] page_sum;
      logic [11:0] base_reg;
      logic [12:0] pages_reg;
      outcome_type awaited[$];
      int          errors;
      int          checked;

      function void push_blk(int o, logic [12:0] f);
         if (recs_used >= bpa_pkg::PAGE_CAPACITY) return;
         free_list[o].push_front(f);
         recs_used++;
         page_sum += 13'(1 << o);
      endfunction

      function bit take_blk(int o, logic [12:0] f);
         for (int k = 0; k < free_list[o].size(); k++) begin
            if (free_list[o][k] == f) begin
               free_list[o].delete(k);
               recs_used--;
               page_sum -= 13'(1 << o);
               return 1;
            end
         end
         return 0;
      endfunction

      function void rebuild();
         int left;
         int o;
         logic [12:0] f;
         for (int i = 0; i < bpa_pkg::ORDER_LIMIT; i++) free_list[i].delete();
         recs_used = 0;
         page_sum = 0;
         f = {1'b0, base_reg};
         if (pages_reg > bpa_pkg::PAGE_CAPACITY - base_reg)
            left = bpa_pkg::PAGE_CAPACITY - base_reg;
         else left = pages_reg;
         while (left > 0) begin
            o = bpa_pkg::ORDER_LIMIT - 1;
            while (o > 0 && (1 << o) > left) o--;
            push_blk(o, f);
            f += 13'(1 << o);
            left -= 1 << o;
         end
      endfunction

      function void write_reg(logic [bpa_pkg::CSR_IDX_W-1:0] idx, logic [12:0] val);
         if (idx == bpa_pkg::CSR_RANGE_BASE) base_reg = val[11:0];
         else pages_reg = val;
         rebuild();
      endfunction

      function outcome_type note_request(logic act, logic [3:0] ord, logic [11:0] frame);
         outcome_type r;
         int c;
         int o;
         logic [11:0] mate;
         logic [11:0] f;
         logic [12:0] b;
         r.granted = 0; r.status = bpa_pkg::STATUS_DONE; r.merged = 0;
         if (ord >= bpa_pkg::ORDER_LIMIT) begin
            r.status = bpa_pkg::STATUS_BAD_ORD;
         end else if (act == bpa_pkg::ACT_ALLOC) begin
            c = ord;
            while (c < bpa_pkg::ORDER_LIMIT && free_list[c].size() == 0) c++;
            if (c >= bpa_pkg::ORDER_LIMIT) begin
               r.status = bpa_pkg::STATUS_NO_FREE;
            end else begin
               b = free_list[c].pop_front();
               recs_used--;
               page_sum -= 13'(1 << c);
               while (c > ord) begin
                  c--;
                  push_blk(c, b + 13'(1 << c));
               end
               r.granted = b[11:0];
            end
         end else begin
            o = ord;
            f = frame;
            while (o < bpa_pkg::ORDER_LIMIT - 1) begin
               mate = f ^ 12'(1 << o);
               if (!take_blk(o, {1'b0, mate})) break;
               if (mate < f) f = mate;
               o++;
            end
            push_blk(o, {1'b0, f});
            r.merged = 4'(o);
         end
         r.total = page_sum;
         awaited.push_back(r);
         return r;
      endfunction

      function void check_result(logic [11:0] g, logic [1:0] s, logic [3:0] m, logic [12:0] t);
         outcome_type e;
         checked++;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat: frame %0d status %0d", g, s);
            return;
         end
         e = awaited.pop_front();
         if (e.granted !== g || e.status !== s || e.merged !== m || e.total !== t) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp frame %0d st %0d ord %0d tot %0d, got %0d %0d %0d %0d",
                        e.granted, e.status, e.merged, e.total, g, s, m, t);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_action = 0;
   logic [3:0]  req_block_order = 0;
   logic [11:0] req_frame_number = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [11:0] rsp_granted_frame;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_merged_order;
   logic [12:0] rsp_free_page_total;
   logic        csr_write_enable = 0;
   logic [bpa_pkg::CSR_IDX_W-1:0] csr_index = bpa_pkg::CSR_RANGE_BASE;
   logic [12:0] csr_write_data = 0;

   alloc_scoreboard sb = new();
   typedef struct { logic [11:0] f; logic [3:0] o; } held_type;
   held_type held[$];
   bit    no_idle = 0;
   int    sent = 0;
   int    idle_cycles = 0;

   buddy_page_allocator_top i_dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   task automatic send(logic act, logic [3:0] ord, logic [11:0] frame);
      int gap;
      outcome_type r;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_block_order <= ord;
      req_frame_number <= frame;
      do @(posedge clock); while (req_stall);
      r = sb.note_request(act, ord, frame);
      sent++;
      if (act == bpa_pkg::ACT_ALLOC && r.status == bpa_pkg::STATUS_DONE)
         held.push_back('{r.granted, ord});
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [bpa_pkg::CSR_IDX_W-1:0] idx, logic [12:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic free_held();
      int k;
      held_type h;
      k = $urandom_range(0, held.size() - 1);
      h = held[k];
      held.delete(k);
      send(bpa_pkg::ACT_FREE, h.o, h.f);
   endtask

   task automatic random_phase(int n);
      int p;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         if (p < 50) send(bpa_pkg::ACT_ALLOC, 4'($urandom_range(0, 4) == 0 ?
                                       $urandom_range(0, 10) : $urandom_range(0, 3)), 12'($urandom));
         else if (p < 88 && held.size() > 0) free_held();
         else if (p < 94) send(bpa_pkg::ACT_FREE, 4'($urandom_range(0, 10)), 12'($urandom));
         else send(1'($urandom), 4'($urandom_range(11, 15)), 12'($urandom));
      end
   endtask

   initial begin
      forever begin
         int n;
         n = no_idle ? 0 : $urandom_range(0, 3);
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!rsp_valid || reset);
         sb.check_result(rsp_granted_frame, rsp_status, rsp_merged_order, rsp_free_page_total);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
         $display("timeout");
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      sb.base_reg = 0;
      sb.pages_reg = 13'd4096;
      sb.rebuild();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every order, failures, merges, misuse
      for (int o = 0; o < 16; o++) send(bpa_pkg::ACT_ALLOC, 4'(o), 12'hFFF);
      send(bpa_pkg::ACT_ALLOC, 4'd10, 12'd0);
      send(bpa_pkg::ACT_ALLOC, 4'd10, 12'd0);
      send(bpa_pkg::ACT_FREE, 4'd0, 12'd0);
      send(bpa_pkg::ACT_FREE, 4'd0, 12'd0);
      send(bpa_pkg::ACT_FREE, 4'd3, 12'd5);
      send(bpa_pkg::ACT_FREE, 4'd0, 12'hFFF);
      send(bpa_pkg::ACT_FREE, 4'd15, 12'hFFF);
      while (held.size() > 0) free_held();
      drain();

      random_phase(200);
      drain();

      write_csr(bpa_pkg::CSR_RANGE_BASE, 13'd0);
      write_csr(bpa_pkg::CSR_RANGE_PAGES, 13'd1);
      held.delete();
      no_idle = 1;
      random_phase(40);
      drain();
      no_idle = 0;

      write_csr(bpa_pkg::CSR_RANGE_BASE, 13'd4095);
      write_csr(bpa_pkg::CSR_RANGE_PAGES, 13'd8191);
      held.delete();
      random_phase(30);
      drain();

      write_csr(bpa_pkg::CSR_RANGE_PAGES, 13'd0);
      held.delete();
      random_phase(20);
      drain();

      write_csr(bpa_pkg::CSR_RANGE_BASE, 13'd100);
      write_csr(bpa_pkg::CSR_RANGE_PAGES, 13'd1000);
      held.delete();
      random_phase(150);
      drain();

      write_csr(bpa_pkg::CSR_RANGE_BASE, 13'd0);
      write_csr(bpa_pkg::CSR_RANGE_PAGES, 13'd4096);
      held.delete();
      random_phase(200);
      drain();
      repeat (50) @(posedge clock);

      $display("covered %0d requests, %0d results checked, over six range settings",
               sent, sb.checked);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
